### hdl/ecp_pkg.sv
// Shared types, constants and modular helpers for the elliptic-curve point unit.
package ecp_pkg;

   localparam int FIELD_BITS  = 16;
   localparam int SCALAR_BITS = 16;
   localparam int FCNT_BITS   = $clog2(FIELD_BITS);
   localparam int SCNT_BITS   = $clog2(SCALAR_BITS);

   typedef logic [FIELD_BITS-1:0]  field_type;
   typedef logic [SCALAR_BITS-1:0] scalar_type;

   // Operation codes
   localparam logic [1:0] CMD_ADD = 2'd0;
   localparam logic [1:0] CMD_MUL = 2'd1;
   localparam logic [1:0] CMD_NEG = 2'd2;
   localparam logic [1:0] CMD_RSV = 2'd3;

   // Register indexes
   localparam logic CSR_CURVE_A = 1'b0;
   localparam logic CSR_MODULUS = 1'b1;

   typedef struct packed {
      logic [1:0] cmd;
      field_type  x_first;
      field_type  y_first;
      field_type  x_second;
      field_type  y_second;
      scalar_type scalar;
   } req_type;

   typedef struct packed {
      field_type res_x;
      field_type res_y;
      logic      no_inverse;
   } rsp_type;

   typedef enum logic {MU_MUL, MU_INV} mu_op_type;

   typedef struct packed {
      logic      go;
      mu_op_type op;
      field_type opa;
      field_type opb;
   } mu_req_type;

   typedef struct packed {
      logic      done;
      logic      ok;
      field_type value;
   } mu_rsp_type;

   // (a + b) mod p for a, b below p
   function automatic field_type add_mod(field_type a, field_type b, field_type p);
      logic [FIELD_BITS:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s >= {1'b0, p}) s = s - {1'b0, p};
      return s[FIELD_BITS-1:0];
   endfunction

   // (a - b) mod p for a, b below p
   function automatic field_type sub_mod(field_type a, field_type b, field_type p);
      field_type d;
      d = a - b;
      if (a < b) d = d + p;
      return d;
   endfunction

endpackage

### hdl/ecp_mod_unit.sv
// Shared modular unit: bit-serial multiply/reduce and shift-subtract Euclid inverse.
module ecp_mod_unit import ecp_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  field_type  modulus,
   input  mu_req_type mu_req,
   output mu_rsp_type mu_rsp
);

   typedef enum logic [1:0] {U_IDLE, U_MUL, U_INV} ustate_type;

   ustate_type               state_ff;
   mu_rsp_type               rsp_ff;
   field_type                a_ff, b_ff, acc_ff;
   logic [FCNT_BITS-1:0]     cnt_ff;
   field_type                r0_ff, r1_ff, t0_ff, t1_ff, u_ff;
   logic [FIELD_BITS:0]      v_ff;

   logic [FIELD_BITS:0]      dbl, dbl_r, sum, sum_r;
   logic [FIELD_BITS+1:0]    v_dbl;
   field_type                acc_in;

   // One multiply bit: acc = 2*acc + bit*a, both reduced below p
   always_comb begin
      dbl   = {acc_ff, 1'b0};
      dbl_r = (dbl >= {1'b0, modulus}) ? dbl - {1'b0, modulus} : dbl;
      sum   = dbl_r + (b_ff[cnt_ff] ? {1'b0, a_ff} : '0);
      sum_r = (sum >= {1'b0, modulus}) ? sum - {1'b0, modulus} : sum;
      acc_in = sum_r[FIELD_BITS-1:0];
      v_dbl = {v_ff, 1'b0};
   end

   assign mu_rsp = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= U_IDLE;
         rsp_ff   <= '0;
      end else begin
         // Pulse done on the last multiply bit or when Euclid runs out
         rsp_ff.done <= ((state_ff == U_MUL) && (cnt_ff == '0)) ||
                        ((state_ff == U_INV) && (r1_ff == '0));
         unique case (state_ff)
            U_IDLE: begin
               if (mu_req.go) begin
                  a_ff   <= mu_req.opa;
                  b_ff   <= mu_req.opb;
                  acc_ff <= '0;
                  cnt_ff <= FCNT_BITS'(FIELD_BITS-1);
                  r0_ff  <= modulus;
                  r1_ff  <= mu_req.opb;
                  t0_ff  <= '0;
                  t1_ff  <= field_type'(1);
                  v_ff   <= {1'b0, mu_req.opb};
                  u_ff   <= field_type'(1);
                  state_ff <= (mu_req.op == MU_MUL) ? U_MUL : U_INV;
               end
            end
            U_MUL: begin
               acc_ff <= acc_in;
               cnt_ff <= cnt_ff - 1'b1;
               if (cnt_ff == '0) begin
                  rsp_ff.ok    <= 1'b1;
                  rsp_ff.value <= acc_in;
                  state_ff     <= U_IDLE;
               end
            end
            U_INV: begin
               if (r1_ff == '0) begin
                  // finish: inverse exists only when the gcd is one
                  rsp_ff.ok    <= (r0_ff == field_type'(1));
                  rsp_ff.value <= t0_ff;
                  state_ff     <= U_IDLE;
               end else if (r0_ff >= r1_ff) begin
                  if (v_dbl <= {2'b0, r0_ff}) begin
                     // grow the shifted divisor and its cofactor
                     v_ff <= v_dbl[FIELD_BITS:0];
                     u_ff <= add_mod(u_ff, u_ff, modulus);
                  end else begin
                     // subtract the largest shifted divisor
                     r0_ff <= r0_ff - v_ff[FIELD_BITS-1:0];
                     t0_ff <= sub_mod(t0_ff, u_ff, modulus);
                     v_ff  <= {1'b0, r1_ff};
                     u_ff  <= t1_ff;
                  end
               end else begin
                  // remainder done: swap the pairs
                  r0_ff <= r1_ff;
                  r1_ff <= r0_ff;
                  t0_ff <= t1_ff;
                  t1_ff <= t0_ff;
                  v_ff  <= {1'b0, r0_ff};
                  u_ff  <= t0_ff;
               end
            end
            default: state_ff <= U_IDLE;
         endcase
      end
   end

endmodule

### hdl/ec_point_add_scalar_mult.sv
// Elliptic-curve affine point add, scalar multiply and negate over a prime field.
//
// Request channel (req_valid/req_stall/req_data): one operation per request,
// cmd 0 adds two points, 1 multiplies the first point by scalar, 2 negates it.
// Result channel (rsp_valid/rsp_stall/rsp_data): exactly one result per request,
// held in place while rsp_stall is high. (0,0) encodes the point at infinity.
// Config port (csr_valid/csr_ready/csr_index/csr_wdata): index 0 is curve_a,
// index 1 the modulus; always ready, write only while idle.
// The block works on one request at a time: req_stall is high from acceptance
// until the result has been taken.
// Field multiplies, inverses and the input reductions go through one shared
// modular unit; additions and subtractions run in the sequencer. An inverse does
// one step per Euclid swap plus, for each quotient, a subtract per set bit with
// the divisor re-doubled from scratch after each subtract. A point add uses at
// most 4 multiplies and one inverse, and none when an operand is infinity. A
// scalar multiply takes up to 2*SCALAR_BITS point adds.
// Reset (synchronous) returns curve_a to 20, the modulus to 29, and idles.
module ec_point_add_scalar_mult import ecp_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      req_valid,
   output logic      req_stall,
   input  req_type   req_data,
   output logic      rsp_valid,
   input  logic      rsp_stall,
   output rsp_type   rsp_data,
   input  logic      csr_valid,
   output logic      csr_ready,
   input  logic      csr_index,
   input  field_type csr_wdata
);

   typedef enum logic [4:0] {
      S_IDLE, S_START, S_RX1, S_RY1, S_RA, S_RX2, S_RY2, S_ROUTE,
      S_M_DBL, S_M_NEXT,
      S_A_CHECK, S_A_SQ, S_A_T2, S_A_T3, S_A_TA, S_A_D2, S_A_INV, S_A_LAM,
      S_A_LL, S_A_S1, S_A_S2, S_A_DX, S_A_M, S_A_RY, S_A_RET, S_OUT
   } state_type;

   typedef enum logic [1:0] {RET_ONE, RET_DBL, RET_ADD} ret_type;

   state_type            state_ff;
   ret_type              ret_ff;
   logic                 issued_ff;
   field_type            curve_a_ff, modulus_ff, a_red_ff;
   req_type              req_ff;
   field_type            x1_ff, y1_ff, x2_ff, y2_ff;
   field_type            px_ff, py_ff, qx_ff, qy_ff, rx_ff, ry_ff;
   field_type            num_ff, den_ff, lam_ff, tmp_ff;
   logic                 fault_ff;
   logic [SCNT_BITS-1:0] bit_ff;

   mu_req_type           mu_req;
   mu_rsp_type           mu_rsp;
   logic [FIELD_BITS:0]  ysum;

   ecp_mod_unit u_mod (
      .clock   (clock),
      .reset   (reset),
      .modulus (modulus_ff),
      .mu_req  (mu_req),
      .mu_rsp  (mu_rsp)
   );

   assign csr_ready = 1'b1;
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_OUT);
   assign rsp_data  = '{res_x: rx_ff, res_y: ry_ff, no_inverse: fault_ff};
   assign ysum      = {1'b0, py_ff} + {1'b0, qy_ff};

   // Drive the shared unit from the current step
   always_comb begin
      mu_req     = '0;
      mu_req.op  = MU_MUL;
      mu_req.opa = field_type'(1);
      case (state_ff)
         S_RX1:   mu_req.opb = req_ff.x_first;
         S_RY1:   mu_req.opb = req_ff.y_first;
         S_RA:    mu_req.opb = curve_a_ff;
         S_RX2:   mu_req.opb = req_ff.x_second;
         S_RY2:   mu_req.opb = req_ff.y_second;
         S_A_SQ:  begin mu_req.opa = px_ff;  mu_req.opb = px_ff;  end
         S_A_INV: begin mu_req.op = MU_INV;  mu_req.opb = den_ff; end
         S_A_LAM: begin mu_req.opa = num_ff; mu_req.opb = tmp_ff; end
         S_A_LL:  begin mu_req.opa = lam_ff; mu_req.opb = lam_ff; end
         S_A_M:   begin mu_req.opa = lam_ff; mu_req.opb = tmp_ff; end
         default: mu_req.opb = '0;
      endcase
      case (state_ff)
         S_RX1, S_RY1, S_RA, S_RX2, S_RY2, S_A_SQ, S_A_INV, S_A_LAM, S_A_LL,
         S_A_M:   mu_req.go = !issued_ff;
         default: mu_req.go = 1'b0;
      endcase
   end

   // Sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         issued_ff  <= 1'b0;
         curve_a_ff <= field_type'(20);
         modulus_ff <= field_type'(29);
         ret_ff     <= RET_ONE;
         fault_ff   <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_CURVE_A: curve_a_ff <= csr_wdata;
               CSR_MODULUS: modulus_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (mu_rsp.done) issued_ff <= 1'b0;
         else if (mu_req.go) issued_ff <= 1'b1;

         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  req_ff   <= req_data;
                  state_ff <= S_START;
               end
            end
            S_START: begin
               fault_ff <= 1'b0;
               rx_ff    <= '0;
               ry_ff    <= '0;
               if (modulus_ff < field_type'(2) || req_ff.cmd == CMD_RSV) state_ff <= S_OUT;
               else state_ff <= S_RX1;
            end
            S_RX1: if (mu_rsp.done) begin x1_ff <= mu_rsp.value; state_ff <= S_RY1; end
            S_RY1: if (mu_rsp.done) begin y1_ff <= mu_rsp.value; state_ff <= S_RA; end
            S_RA: if (mu_rsp.done) begin
               a_red_ff <= mu_rsp.value;
               state_ff <= (req_ff.cmd == CMD_ADD) ? S_RX2 : S_ROUTE;
            end
            S_RX2: if (mu_rsp.done) begin x2_ff <= mu_rsp.value; state_ff <= S_RY2; end
            S_RY2: if (mu_rsp.done) begin y2_ff <= mu_rsp.value; state_ff <= S_ROUTE; end
            S_ROUTE: begin
               unique case (req_ff.cmd)
                  CMD_ADD: begin
                     px_ff <= x1_ff; py_ff <= y1_ff; qx_ff <= x2_ff; qy_ff <= y2_ff;
                     ret_ff   <= RET_ONE;
                     state_ff <= S_A_CHECK;
                  end
                  CMD_MUL: begin
                     bit_ff   <= SCNT_BITS'(SCALAR_BITS-1);
                     state_ff <= S_M_DBL;
                  end
                  default: begin
                     rx_ff    <= x1_ff;
                     ry_ff    <= sub_mod('0, y1_ff, modulus_ff);
                     state_ff <= S_OUT;
                  end
               endcase
            end
            // Double the running point
            S_M_DBL: begin
               px_ff <= rx_ff; py_ff <= ry_ff; qx_ff <= rx_ff; qy_ff <= ry_ff;
               ret_ff   <= RET_DBL;
               state_ff <= S_A_CHECK;
            end
            S_M_NEXT: begin
               bit_ff   <= bit_ff - 1'b1;
               state_ff <= (bit_ff == '0) ? S_OUT : S_M_DBL;
            end
            // Point add: special cases, then pick slope
            S_A_CHECK: begin
               if (px_ff == qx_ff && (ysum == '0 || ysum == {1'b0, modulus_ff})) begin
                  rx_ff <= '0; ry_ff <= '0; state_ff <= S_A_RET;
               end else if (px_ff == '0 && py_ff == '0) begin
                  rx_ff <= qx_ff; ry_ff <= qy_ff; state_ff <= S_A_RET;
               end else if (qx_ff == '0 && qy_ff == '0) begin
                  rx_ff <= px_ff; ry_ff <= py_ff; state_ff <= S_A_RET;
               end else if (px_ff == qx_ff && py_ff == qy_ff) begin
                  state_ff <= S_A_SQ;
               end else begin
                  num_ff   <= sub_mod(qy_ff, py_ff, modulus_ff);
                  den_ff   <= sub_mod(qx_ff, px_ff, modulus_ff);
                  state_ff <= S_A_INV;
               end
            end
            S_A_SQ: if (mu_rsp.done) begin
               tmp_ff <= mu_rsp.value; num_ff <= mu_rsp.value; state_ff <= S_A_T2;
            end
            S_A_T2: begin num_ff <= add_mod(num_ff, tmp_ff, modulus_ff); state_ff <= S_A_T3; end
            S_A_T3: begin num_ff <= add_mod(num_ff, tmp_ff, modulus_ff); state_ff <= S_A_TA; end
            S_A_TA: begin num_ff <= add_mod(num_ff, a_red_ff, modulus_ff); state_ff <= S_A_D2; end
            S_A_D2: begin den_ff <= add_mod(py_ff, py_ff, modulus_ff); state_ff <= S_A_INV; end
            S_A_INV: if (mu_rsp.done) begin
               if (mu_rsp.ok) begin
                  tmp_ff   <= mu_rsp.value;
                  state_ff <= S_A_LAM;
               end else begin
                  lam_ff   <= '0;
                  fault_ff <= 1'b1;
                  state_ff <= S_A_LL;
               end
            end
            S_A_LAM: if (mu_rsp.done) begin lam_ff <= mu_rsp.value; state_ff <= S_A_LL; end
            S_A_LL:  if (mu_rsp.done) begin tmp_ff <= mu_rsp.value; state_ff <= S_A_S1; end
            S_A_S1: begin tmp_ff <= sub_mod(tmp_ff, px_ff, modulus_ff); state_ff <= S_A_S2; end
            S_A_S2: begin rx_ff <= sub_mod(tmp_ff, qx_ff, modulus_ff); state_ff <= S_A_DX; end
            S_A_DX: begin tmp_ff <= sub_mod(px_ff, rx_ff, modulus_ff); state_ff <= S_A_M; end
            S_A_M:  if (mu_rsp.done) begin tmp_ff <= mu_rsp.value; state_ff <= S_A_RY; end
            S_A_RY: begin ry_ff <= sub_mod(tmp_ff, py_ff, modulus_ff); state_ff <= S_A_RET; end
            // Return to the caller of the point add
            S_A_RET: begin
               unique case (ret_ff)
                  RET_DBL: begin
                     if (req_ff.scalar[bit_ff]) begin
                        px_ff <= rx_ff; py_ff <= ry_ff; qx_ff <= x1_ff; qy_ff <= y1_ff;
                        ret_ff   <= RET_ADD;
                        state_ff <= S_A_CHECK;
                     end else begin
                        state_ff <= S_M_NEXT;
                     end
                  end
                  RET_ADD: state_ff <= S_M_NEXT;
                  default: state_ff <= S_OUT;
               endcase
            end
            S_OUT: if (!rsp_stall) state_ff <= S_IDLE;
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

### hdl/ecp_checker.sv
// Port-level checker for the point unit, bound to the top level.
module ecp_checker import ecp_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   // A stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   // Only one request in flight: a result blocks new requests
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("request accepted while result pending");

   // An accepted request never yields a result in the next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> !rsp_valid && req_stall)
      else $error("result too early after request");

   // A taken result is not repeated
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall |=> !rsp_valid)
      else $error("result repeated");

endmodule

bind ec_point_add_scalar_mult ecp_checker u_ecp_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
